FILE: rtl/chained_xor_table_cipher_assert.svh
// Assertion macros shared by the cipher RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef CHAINED_XOR_TABLE_CIPHER_ASSERT_SVH
`define CHAINED_XOR_TABLE_CIPHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CXTC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CXTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cxtc_pkg.sv
// Shared constants, types and generator arithmetic for the chained XOR table cipher.
// Depends on nothing.
package cxtc_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int BANK_DEPTH  = TABLE_DEPTH / 2;
	localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int KEY_AW      = BANK_AW + 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int SEED_W   = 31;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = SEED_W;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_SEED     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 1'b1;

	localparam logic [14:0]       PM_MULT      = 15'd16807;
	localparam logic [SEED_W-1:0] PM_MOD       = 31'h7FFF_FFFF;
	localparam logic [SEED_W-1:0] DEFAULT_SEED = 31'd666666;

	typedef struct packed {
		logic               en;
		logic               bank;
		logic [BANK_AW-1:0] addr;
		logic [7:0]         data;
	} key_wr_t;

	// seed mod (2^31-1), zero taken as one
	function automatic logic [SEED_W-1:0] norm_seed(input logic [SEED_W-1:0] s);
		return ((s == '0) || (s == PM_MOD)) ? SEED_W'(1) : s;
	endfunction

	// s*16807 mod (2^31-1), folded on the Mersenne modulus
	function automatic logic [SEED_W-1:0] pm_next(input logic [SEED_W-1:0] s);
		logic [45:0] p;
		logic [31:0] t;
		logic [31:0] u;
		p = 46'(s) * 46'(PM_MULT);
		t = 32'(p[30:0]) + 32'(p[45:31]);
		u = t - 32'(PM_MOD);
		return (t >= 32'(PM_MOD)) ? u[SEED_W-1:0] : t[SEED_W-1:0];
	endfunction

endpackage

FILE: rtl/cxtc_key_ram.sv
// Key table split into even and odd banks, one synchronous read port each.
// Depends on cxtc_pkg; written by the key generator.
module cxtc_key_ram (
	input  logic                         clk,
	input  cxtc_pkg::key_wr_t            wr,
	input  logic                         rd_en,
	input  logic [cxtc_pkg::BANK_AW-1:0] rd_addr,
	output logic [7:0]                   even_q,
	output logic [7:0]                   odd_q
);

	logic [7:0] mem_even [cxtc_pkg::BANK_DEPTH];
	logic [7:0] mem_odd  [cxtc_pkg::BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en && !wr.bank) begin
			mem_even[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			even_q <= mem_even[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.bank) begin
			mem_odd[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			odd_q <= mem_odd[rd_addr];
		end
	end

endmodule

FILE: rtl/cxtc_keygen.sv
// Park-Miller sequencer that fills the key table, one entry per cycle.
// Depends on cxtc_pkg and the assertion macro header.
`include "chained_xor_table_cipher_assert.svh"

module cxtc_keygen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seed_wr,
	input  logic [cxtc_pkg::SEED_W-1:0] seed_val,
	output cxtc_pkg::key_wr_t           wr,
	output logic                        busy
);

	logic [cxtc_pkg::SEED_W-1:0] gen_q;
	logic [cxtc_pkg::CNT_W-1:0]  cnt_q;
	logic [cxtc_pkg::SEED_W-1:0] gen_next;

	assign gen_next = cxtc_pkg::pm_next(gen_q);
	assign busy     = (cnt_q != cxtc_pkg::CNT_W'(cxtc_pkg::TABLE_DEPTH));

	always_comb begin
		wr.en   = busy;
		wr.bank = cnt_q[0];
		wr.addr = cnt_q[cxtc_pkg::KEY_AW-1:1];
		wr.data = gen_next[cxtc_pkg::SEED_W-1:cxtc_pkg::SEED_W-8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= cxtc_pkg::norm_seed(cxtc_pkg::DEFAULT_SEED);
			cnt_q <= '0;
		end else if (seed_wr) begin
			gen_q <= cxtc_pkg::norm_seed(seed_val);
			cnt_q <= '0;
		end else if (busy) begin
			gen_q <= gen_next;
			cnt_q <= cnt_q + cxtc_pkg::CNT_W'(1);
		end
	end

	`CXTC_ASSERT_NOW(a_gen_nonzero, clk, arst_n, busy, gen_q != '0, "generator state hit zero")
	`CXTC_ASSERT_NEXT(a_refill, clk, arst_n, seed_wr, cnt_q == '0, "seed write did not restart fill")
	`CXTC_ASSERT_NEXT(a_done_holds, clk, arst_n, !busy && !seed_wr, !busy, "fill restarted unasked")

endmodule

FILE: rtl/chained_xor_table_cipher.sv
// Chained XOR table cipher top level: config port, byte pipeline and chaining.
// Depends on cxtc_pkg, cxtc_keygen, cxtc_key_ram and the assertion macro header.
// A byte is registered in stage 1, with its key table read (even and odd bank),
// then in the output register; one byte per cycle while no fill or stall holds it.
// Reset and every key_seed write refill the 512-entry table; no input is taken meanwhile.
// Reset clears chain byte, key index and mode; decrypt_mode resets to 0.
`include "chained_xor_table_cipher_assert.svh"

module chained_xor_table_cipher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cxtc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cxtc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	input  logic                            first_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic                            overlong
);

	cxtc_pkg::key_wr_t          key_wr;
	logic                       fill_busy;
	logic                       seed_wr;
	logic                       decrypt_q;
	logic                       accept;
	logic                       adv_s1;
	logic [cxtc_pkg::BANK_AW-1:0] rd_addr;
	logic                       wrap_eff;
	logic                       last_pair;
	logic [cxtc_pkg::BANK_AW-1:0] ki_q;
	logic                       wrap_q;
	logic                       valid_s1;
	logic [7:0]                 data_s1;
	logic                       first_s1;
	logic                       ovl_s1;
	logic [7:0]                 key_even;
	logic [7:0]                 key_odd;
	logic [7:0]                 chain_q;
	logic [7:0]                 chain_eff;
	logic [7:0]                 res;
	logic [7:0]                 chain_new;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       overlong_q;

	assign seed_wr = cfg_we && (cfg_index == cxtc_pkg::CFG_KEY_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
		end else if (cfg_we && (cfg_index == cxtc_pkg::CFG_DECRYPT_MODE)) begin
			decrypt_q <= cfg_data[0];
		end
	end

	cxtc_keygen u_keygen (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed_wr  (seed_wr),
		.seed_val (cfg_data),
		.wr       (key_wr),
		.busy     (fill_busy)
	);

	cxtc_key_ram u_key_ram (
		.clk     (clk),
		.wr      (key_wr),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.even_q  (key_even),
		.odd_q   (key_odd)
	);

	// stage 1: accept, issue table read, advance key index
	assign adv_s1    = !out_valid_q || out_ready;
	assign in_ready  = !fill_busy && (!valid_s1 || adv_s1);
	assign accept    = in_valid && in_ready;
	assign rd_addr   = first_byte ? '0 : ki_q;
	assign wrap_eff  = !first_byte && wrap_q;
	assign last_pair = (rd_addr == cxtc_pkg::BANK_AW'(cxtc_pkg::BANK_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ki_q     <= '0;
			wrap_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				ki_q   <= last_pair ? '0 : rd_addr + cxtc_pkg::BANK_AW'(1);
				wrap_q <= wrap_eff || last_pair;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			ovl_s1   <= wrap_eff;
		end
	end

	// stage 2: combine with key bytes and chain byte
	assign chain_eff = first_s1 ? 8'h00 : chain_q;
	assign res       = data_s1 ^ key_even ^ chain_eff;
	assign chain_new = (decrypt_q ? data_s1 : res) ^ key_odd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q     <= 8'h00;
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			chain_q     <= chain_new;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			out_byte_q <= res;
			overlong_q <= ovl_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign overlong  = overlong_q;

	`CXTC_ASSERT_NOW(a_no_accept_fill, clk, arst_n, accept, !fill_busy, "transaction taken during fill")
	`CXTC_ASSERT_NOW(a_stall_blocks, clk, arst_n, valid_s1 && out_valid_q && !out_ready, !in_ready, "stage 1 overrun")
	`CXTC_ASSERT_NEXT(a_first_index, clk, arst_n, accept && first_byte, (ki_q == cxtc_pkg::BANK_AW'(1)) && !wrap_q, "first byte did not restart index")
	`CXTC_ASSERT_NEXT(a_s1_result, clk, arst_n, valid_s1 && adv_s1, out_valid_q, "stage 1 item lost")

endmodule
